// File: hw/rtl/pbkd_pkg.sv
// Shared types and constants for the packed-archive byte keystream decryptor.
// No dependencies; used by pack_byte_keystream_decrypt_unit.
`default_nettype none

package pbkd_pkg;

  // Operation codes carried by an input item
  typedef enum logic [1:0] {
    OP_DECRYPT = 2'd0,
    OP_SKIP    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ENCRYPT_ENABLE = 3'd0,
    REG_KEY_A_LOW      = 3'd1,
    REG_KEY_A_HIGH     = 3'd2,
    REG_KEY_B_LOW      = 3'd3,
    REG_KEY_B_HIGH     = 3'd4,
    REG_START_NUMBER   = 3'd5
  } reg_idx_t;

  localparam int unsigned CfgDataWidth = 64;
  localparam int unsigned CfgIdxWidth  = 3;

  // Multiply-high reciprocals for division by 12 and by 7
  localparam logic [31:0] MulHiDiv12 = 32'hAAAA_AAAB;
  localparam logic [31:0] MulHiDiv7  = 32'h2492_4925;

  // Keystream start state
  localparam logic [3:0] IndexAStart = 4'd0;
  localparam logic [3:0] IndexBStart = 4'd8;
  // Wrap limits
  localparam logic [4:0] IndexAMax   = 5'd15;
  localparam logic [4:0] IndexBWrap  = 5'd12;
  localparam logic [4:0] IndexBPass  = 5'd8;

  // Keystream state
  typedef struct packed {
    logic [3:0] index_a;
    logic [3:0] index_b;
    logic [6:0] string_number;
    logic       swap_flag;
  } ks_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/pack_byte_keystream_decrypt_unit.sv
// An accepted item is held in the input register; its plain byte then goes to the
// output register once it is free. Throughput: one item per cycle unless a decrypt
// waits on a stalled output; the keystream update is one pass of logic in stage 2.
// Reset (rst, synchronous, active high): configuration registers cleared, index_a 0,
// index_b 8, string number 0, swap flag clear, pipeline empty.
// Depends on pbkd_pkg for operation codes, register indexes and constants.
`default_nettype none

module pack_byte_keystream_decrypt_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            operation,
  input  wire logic [7:0]                            cipher_byte,
  // output channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [7:0]                                 plain_byte,
  // configuration write port
  input  wire logic                                  cfg_write,
  input  wire logic [pbkd_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  wire logic [pbkd_pkg::CfgDataWidth-1:0]     cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        encrypt_enable;
  logic [63:0] key_a_low;
  logic [63:0] key_a_high;
  logic [63:0] key_b_low;
  logic [63:0] key_b_high;
  logic [6:0]  start_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      encrypt_enable <= 1'b0;
      key_a_low      <= '0;
      key_a_high     <= '0;
      key_b_low      <= '0;
      key_b_high     <= '0;
      start_number   <= '0;
    end else if (cfg_write) begin
      case (pbkd_pkg::reg_idx_t'(cfg_index))
        pbkd_pkg::REG_ENCRYPT_ENABLE: encrypt_enable <= cfg_data[0];
        pbkd_pkg::REG_KEY_A_LOW:      key_a_low      <= cfg_data;
        pbkd_pkg::REG_KEY_A_HIGH:     key_a_high     <= cfg_data;
        pbkd_pkg::REG_KEY_B_LOW:      key_b_low      <= cfg_data;
        pbkd_pkg::REG_KEY_B_HIGH:     key_b_high     <= cfg_data;
        pbkd_pkg::REG_START_NUMBER:   start_number   <= cfg_data[6:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic              s1_valid;
  pbkd_pkg::op_t     s1_op;
  logic [7:0]        s1_byte;
  logic              s1_fire;    // stage 1 item moves on this cycle
  logic              out_free;   // output register can take a new byte
  logic              in_accept;

  // Only a decrypt needs room in the output register; skip, restart and
  // unused items retire straight away.
  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && (out_free || (s1_op != pbkd_pkg::OP_DECRYPT));
  assign in_stall  = s1_valid && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload holds unless a new item is taken
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op   <= pbkd_pkg::op_t'(operation);
      s1_byte <= cipher_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: keystream state, decrypt and advance
  // ---------------------------------------------------------------------------
  pbkd_pkg::ks_state_t ks;
  pbkd_pkg::ks_state_t ks_next;
  pbkd_pkg::ks_state_t ks_adv;     // state after one advance
  pbkd_pkg::ks_state_t ks_start;   // state loaded by a restart

  // Key tables as 128-bit words, byte i in bits 8i+7:8i
  logic [127:0] key_a;
  logic [127:0] key_b;
  logic [7:0]   key_a_byte;
  logic [7:0]   key_b_byte;
  logic [7:0]   mixed;
  logic [7:0]   swapped;
  logic [7:0]   decrypted;

  assign key_a      = {key_a_high, key_a_low};
  assign key_b      = {key_b_high, key_b_low};
  assign key_a_byte = key_a[{ks.index_a, 3'b000} +: 8];
  assign key_b_byte = key_b[{ks.index_b, 3'b000} +: 8];
  assign mixed      = s1_byte ^ key_b_byte ^ {1'b0, ks.string_number};
  assign swapped    = ks.swap_flag ? {mixed[3:0], mixed[7:4]} : mixed;
  assign decrypted  = swapped ^ key_a_byte;

  assign ks_start.index_a       = pbkd_pkg::IndexAStart;
  assign ks_start.index_b       = pbkd_pkg::IndexBStart;
  assign ks_start.string_number = start_number;
  assign ks_start.swap_flag     = 1'b0;

  // String number step and its remainders by 7 and by 12 (multiply-high)
  logic [4:0]  a_inc;
  logic [4:0]  b_inc;
  logic [6:0]  num_step;
  logic [38:0] prod12;
  logic [38:0] prod7;
  logic [6:0]  k12;
  logic [6:0]  k7;
  logic [6:0]  t7;
  logic [3:0]  div12;
  logic [4:0]  div7;
  logic [6:0]  rem12_w;
  logic [6:0]  rem7_w;
  logic [3:0]  mod12;
  logic [2:0]  mod7;

  assign a_inc    = {1'b0, ks.index_a} + 5'd1;
  assign b_inc    = {1'b0, ks.index_b} + 5'd1;
  assign num_step = ks.string_number + 7'd2;
  assign prod12   = 39'(pbkd_pkg::MulHiDiv12) * 39'(num_step);
  assign prod7    = 39'(pbkd_pkg::MulHiDiv7) * 39'(num_step);
  assign k12      = prod12[38:32];
  assign k7       = prod7[38:32];
  assign t7       = k7 + ((num_step - k7) >> 1);
  assign div12    = k12[6:3];
  assign div7     = t7[6:2];
  assign rem12_w  = num_step - 7'({div12, 3'b000} + {1'b0, div12, 2'b00});
  assign rem7_w   = num_step - 7'(7'(div7) * 7'd7);
  assign mod12    = rem12_w[3:0];
  assign mod7     = rem7_w[2:0];

  always_comb begin
    ks_adv = ks;
    if (a_inc <= pbkd_pkg::IndexAMax) begin
      // index A still in range: wrap index B past 12
      ks_adv.index_a = a_inc[3:0];
      if (b_inc > pbkd_pkg::IndexBWrap) begin
        ks_adv.index_b   = 4'd0;
        ks_adv.swap_flag = !ks.swap_flag;
      end else begin
        ks_adv.index_b = b_inc[3:0];
      end
    end else if (b_inc <= pbkd_pkg::IndexBPass) begin
      // index A overflow with index B early: restart A only
      ks_adv.index_a   = 4'd0;
      ks_adv.index_b   = b_inc[3:0];
      ks_adv.swap_flag = !ks.swap_flag;
    end else begin
      // full pass done: step the string number and derive new indices
      ks_adv.string_number = num_step;
      if (ks.swap_flag) begin
        ks_adv.swap_flag = 1'b0;
        ks_adv.index_a   = {1'b0, mod7};
        ks_adv.index_b   = mod12 + 4'd2;
      end else begin
        ks_adv.swap_flag = 1'b1;
        ks_adv.index_b   = {1'b0, mod7};
        ks_adv.index_a   = mod12 + 4'd3;
      end
    end
  end

  always_comb begin
    ks_next = ks;
    if (s1_fire && encrypt_enable) begin
      case (s1_op)
        pbkd_pkg::OP_DECRYPT: ks_next = ks_adv;
        pbkd_pkg::OP_SKIP:    ks_next = ks_adv;
        pbkd_pkg::OP_RESTART: ks_next = ks_start;
        default:              ks_next = ks;   // unused code: no effect
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ks.index_a       <= pbkd_pkg::IndexAStart;
      ks.index_b       <= pbkd_pkg::IndexBStart;
      ks.string_number <= '0;
      ks.swap_flag     <= 1'b0;
    end else begin
      ks <= ks_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold a result until it is taken
  // ---------------------------------------------------------------------------
  logic emit;

  assign emit = s1_fire && (s1_op == pbkd_pkg::OP_DECRYPT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Pass the byte through unchanged when encryption is off
  always_ff @(posedge clk) begin
    if (emit) begin
      plain_byte <= encrypt_enable ? decrypted : s1_byte;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_pack_byte_keystream_decrypt_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for pack_byte_keystream_decrypt_unit: sends decrypt, skip, restart
// and unused items under several key settings and checks each plain byte against its own
// keystream predictor. Depends on pbkd_pkg for operation codes and register indexes.

module tb_pack_byte_keystream_decrypt_unit;

  localparam int unsigned QuietLimit   = 2000;  // cycles with no handshake before giving up
  localparam int unsigned SettleCycles = 6;     // margin for the pipeline to drain

  // Predictor's copy of the keystream position
  typedef struct packed {
    logic [3:0] idx_a;
    logic [3:0] idx_b;
    logic [6:0] number;
    logic       swapped;
  } stream_t;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  logic [1:0]                        operation;
  logic [7:0]                        cipher_byte;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [7:0]                        plain_byte;
  logic                              cfg_write;
  logic [pbkd_pkg::CfgIdxWidth-1:0]  cfg_index;
  logic [pbkd_pkg::CfgDataWidth-1:0] cfg_data;

  // Register shadow and keystream as the predictor sees them
  logic         enabled   = 1'b0;
  logic [127:0] key_a     = '0;
  logic [127:0] key_b     = '0;
  logic [6:0]   start_num = '0;
  stream_t      stream;

  logic [7:0]  plain_expected[$];
  int unsigned fail_count     = 0;
  int unsigned items_sent     = 0;
  int unsigned bytes_checked  = 0;
  int unsigned skips_sent     = 0;
  int unsigned restarts_sent  = 0;
  int unsigned number_steps   = 0;
  int unsigned settings_used  = 0;
  bit          idling         = 1'b0;
  int unsigned stall_left     = 0;

  pack_byte_keystream_decrypt_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .cipher_byte(cipher_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .plain_byte (plain_byte),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic stream_t stream_origin(logic [6:0] num);
    stream_t s;
    s.idx_a   = 4'd0;
    s.idx_b   = 4'd8;
    s.number  = num;
    s.swapped = 1'b0;
    return s;
  endfunction

  // Step both key positions by one byte, following the pass wrap rules
  function automatic stream_t advance_stream(stream_t s);
    logic [4:0] a;
    logic [4:0] b;
    logic [6:0] n;
    a = {1'b0, s.idx_a} + 5'd1;
    b = {1'b0, s.idx_b} + 5'd1;
    if (a <= 5'd15) begin
      if (b > 5'd12) begin
        b = '0;
        s.swapped = ~s.swapped;
      end
    end else if (b <= 5'd8) begin
      a = '0;
      s.swapped = ~s.swapped;
    end else begin
      // end of a full pass: step the string number and reseed both positions from it
      n = s.number + 7'd2;
      s.number = n;
      if (s.swapped) begin
        a = 5'(n % 7);
        b = 5'(n % 12) + 5'd2;
      end else begin
        b = 5'(n % 7);
        a = 5'(n % 12) + 5'd3;
      end
      s.swapped = ~s.swapped;
    end
    s.idx_a = a[3:0];
    s.idx_b = b[3:0];
    return s;
  endfunction

  // Apply one accepted item to the predictor and queue its plain byte, if any
  task automatic predict_plain(pbkd_pkg::op_t op, logic [7:0] c);
    logic [7:0] x;
    logic [6:0] old_number;
    old_number = stream.number;
    case (op)
      pbkd_pkg::OP_DECRYPT: begin
        if (!enabled) begin
          plain_expected.push_back(c);
        end else begin
          x = c ^ key_b[{stream.idx_b, 3'b000} +: 8] ^ {1'b0, stream.number};
          if (stream.swapped) x = {x[3:0], x[7:4]};
          x = x ^ key_a[{stream.idx_a, 3'b000} +: 8];
          stream = advance_stream(stream);
          plain_expected.push_back(x);
        end
      end
      pbkd_pkg::OP_SKIP: begin
        skips_sent++;
        if (enabled) stream = advance_stream(stream);
      end
      pbkd_pkg::OP_RESTART: begin
        restarts_sent++;
        if (enabled) stream = stream_origin(start_num);
      end
      pbkd_pkg::OP_NONE: ;
      default: ;
    endcase
    if (op != pbkd_pkg::OP_RESTART && stream.number != old_number) number_steps++;
  endtask

  // Offer one item, with an optional idle burst first; predict it once accepted
  task automatic send_item(pbkd_pkg::op_t op, logic [7:0] c);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    cipher_byte <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_plain(op, c);
    items_sent++;
  endtask

  // Hold the sender off until every plain byte is back, then let skips drain
  task automatic await_plain_bytes();
    in_valid <= 1'b0;
    while (plain_expected.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Caller lowers cfg_write after its last write
  task automatic write_reg(pbkd_pkg::reg_idx_t idx, logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      pbkd_pkg::REG_ENCRYPT_ENABLE: enabled          = data[0];
      pbkd_pkg::REG_KEY_A_LOW:      key_a[63:0]      = data;
      pbkd_pkg::REG_KEY_A_HIGH:     key_a[127:64]    = data;
      pbkd_pkg::REG_KEY_B_LOW:      key_b[63:0]      = data;
      pbkd_pkg::REG_KEY_B_HIGH:     key_b[127:64]    = data;
      pbkd_pkg::REG_START_NUMBER:   start_num        = data[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [63:0] en, logic [63:0] ka_lo, logic [63:0] ka_hi,
                                logic [63:0] kb_lo, logic [63:0] kb_hi, logic [63:0] num);
    await_plain_bytes();
    write_reg(pbkd_pkg::REG_ENCRYPT_ENABLE, en);
    write_reg(pbkd_pkg::REG_KEY_A_LOW, ka_lo);
    write_reg(pbkd_pkg::REG_KEY_A_HIGH, ka_hi);
    write_reg(pbkd_pkg::REG_KEY_B_LOW, kb_lo);
    write_reg(pbkd_pkg::REG_KEY_B_HIGH, kb_hi);
    write_reg(pbkd_pkg::REG_START_NUMBER, num);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Out of reset encryption is off: every operation leaves bytes untouched
  task automatic test_passthrough();
    send_item(pbkd_pkg::OP_DECRYPT, 8'h00);
    send_item(pbkd_pkg::OP_DECRYPT, 8'hFF);
    send_item(pbkd_pkg::OP_SKIP, 8'h11);
    send_item(pbkd_pkg::OP_RESTART, 8'h22);
    send_item(pbkd_pkg::OP_NONE, 8'h33);
    send_item(pbkd_pkg::OP_DECRYPT, 8'hA5);
  endtask

  // Extreme keys and the highest start number; distinct key B bytes expose index errors
  task automatic test_keystream_extremes();
    apply_settings(64'd1, '1, '0, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908, 64'h7F);
    send_item(pbkd_pkg::OP_RESTART, 8'h00);
    send_item(pbkd_pkg::OP_DECRYPT, 8'h00);
    send_item(pbkd_pkg::OP_DECRYPT, 8'hFF);
    send_item(pbkd_pkg::OP_SKIP, 8'h00);
    send_item(pbkd_pkg::OP_NONE, 8'hFF);
    send_item(pbkd_pkg::OP_DECRYPT, 8'h5A);
  endtask

  // With encryption off, skip and restart must not move the keystream
  task automatic test_disabled_holds_stream();
    send_item(pbkd_pkg::OP_DECRYPT, 8'h12);
    send_item(pbkd_pkg::OP_DECRYPT, 8'h34);
    await_plain_bytes();
    write_reg(pbkd_pkg::REG_ENCRYPT_ENABLE, 64'd0);
    cfg_write <= 1'b0;
    send_item(pbkd_pkg::OP_SKIP, 8'h00);
    send_item(pbkd_pkg::OP_RESTART, 8'h00);
    send_item(pbkd_pkg::OP_DECRYPT, 8'h81);
    await_plain_bytes();
    write_reg(pbkd_pkg::REG_ENCRYPT_ENABLE, 64'd1);
    cfg_write <= 1'b0;
    send_item(pbkd_pkg::OP_DECRYPT, 8'h56);
    send_item(pbkd_pkg::OP_DECRYPT, 8'h78);
  endtask

  // A new start number waits for the next restart
  task automatic test_start_number_write();
    await_plain_bytes();
    write_reg(pbkd_pkg::REG_START_NUMBER, 64'h2A);
    cfg_write <= 1'b0;
    send_item(pbkd_pkg::OP_DECRYPT, 8'h9C);
    send_item(pbkd_pkg::OP_DECRYPT, 8'h9C);
    send_item(pbkd_pkg::OP_RESTART, 8'h00);
    send_item(pbkd_pkg::OP_DECRYPT, 8'h9C);
    send_item(pbkd_pkg::OP_DECRYPT, 8'h9C);
  endtask

  // Restart-led streams with random content; one phase seek-heavy, one disabled,
  // the last with no idling on either side
  task automatic test_random_stream();
    pbkd_pkg::op_t op;
    int unsigned   pick;
    int unsigned   skip_share;
    logic [63:0]   en_word;
    logic [63:0]   num_word;
    logic [63:0]   ka_lo, ka_hi, kb_lo, kb_hi;
    for (int phase = 0; phase < 8; phase++) begin
      en_word     = {$urandom, $urandom};
      en_word[0]  = (phase != 4);
      num_word    = {$urandom, $urandom};
      if (phase == 0) num_word[6:0] = '0;
      if (phase == 1) num_word[6:0] = '1;
      ka_lo = {$urandom, $urandom};
      ka_hi = {$urandom, $urandom};
      kb_lo = {$urandom, $urandom};
      kb_hi = {$urandom, $urandom};
      if (phase == 1) {ka_lo, ka_hi, kb_lo, kb_hi} = '1;
      if (phase == 2) {ka_lo, ka_hi, kb_lo, kb_hi} = '0;
      apply_settings(en_word, ka_lo, ka_hi, kb_lo, kb_hi, num_word);
      idling     = (phase < 7);
      skip_share = (phase == 5) ? 75 : 30;
      send_item(pbkd_pkg::OP_RESTART, 8'($urandom));
      for (int i = 0; i < 49; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3)                   op = pbkd_pkg::OP_RESTART;
        else if (pick < 7)              op = pbkd_pkg::OP_NONE;
        else if (pick < 7 + skip_share) op = pbkd_pkg::OP_SKIP;
        else                            op = pbkd_pkg::OP_DECRYPT;
        send_item(op, 8'($urandom));
      end
    end
  endtask

  // Receiver: random stall bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted plain byte with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (plain_expected.size() == 0) begin
        $error("plain_byte: nothing expected, actual %02h", plain_byte);
        fail_count++;
      end else begin
        if (plain_byte !== plain_expected[0]) begin
          $error("plain_byte: expected %02h, actual %02h", plain_expected[0], plain_byte);
          fail_count++;
        end
        void'(plain_expected.pop_front());
        bytes_checked++;
      end
    end
  end

  // Watchdog: drop the run if no item moves on either channel for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("pack_byte_keystream_decrypt_unit verification failed");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    operation   = pbkd_pkg::OP_DECRYPT;
    cipher_byte = 8'h00;
    cfg_write   = 1'b0;
    cfg_index   = pbkd_pkg::REG_ENCRYPT_ENABLE;
    cfg_data    = '0;
    stream      = stream_origin(7'd0);
    repeat (3) @(posedge clk);
    rst    <= 1'b0;
    idling = 1'b1;

    test_passthrough();
    test_keystream_extremes();
    test_disabled_holds_stream();
    test_start_number_write();
    test_random_stream();
    await_plain_bytes();

    $display("Sent %0d items (%0d skips, %0d restarts) under %0d key settings;",
             items_sent, skips_sent, restarts_sent, settings_used);
    $display("checked %0d plain bytes, string number stepped %0d times.",
             bytes_checked, number_steps);
    if (fail_count == 0 && plain_expected.size() == 0)
      $display("pack_byte_keystream_decrypt_unit verification clean");
    else
      $display("pack_byte_keystream_decrypt_unit verification failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pbkd_pkg.sv
hw/rtl/pack_byte_keystream_decrypt_unit.sv
dv/tb_pack_byte_keystream_decrypt_unit.sv
